// ===== sv/xie_pkg.sv =====
// Shared types, slot indices and the ModRM builder for the instruction encoder.
// Used by xie_front, xie_queue, xie_back and x86_instruction_encoder.
package xie_pkg;

   localparam int NumSlots = 13;
   localparam int SlotW    = $clog2(NumSlots);

   // Fixed byte positions of an encoded instruction, emitted in this order
   localparam logic [SlotW-1:0] SlotPrefix = SlotW'(0);
   localparam logic [SlotW-1:0] SlotRex    = SlotW'(1);
   localparam logic [SlotW-1:0] SlotOp3    = SlotW'(2);
   localparam logic [SlotW-1:0] SlotOp2    = SlotW'(3);
   localparam logic [SlotW-1:0] SlotOp1    = SlotW'(4);
   localparam logic [SlotW-1:0] SlotOp0    = SlotW'(5);
   localparam logic [SlotW-1:0] SlotModrm  = SlotW'(6);
   localparam logic [SlotW-1:0] SlotSib    = SlotW'(7);
   localparam logic [SlotW-1:0] SlotImm8   = SlotW'(8);
   localparam logic [SlotW-1:0] SlotImm32  = SlotW'(9);

   // form bit positions
   localparam int FbSingle = 0;
   localparam int FbSib    = 1;
   localparam int FbMem    = 2;
   localparam int FbImm8   = 3;
   localparam int FbImm32  = 4;
   localparam int FbSame   = 5;
   localparam int FbPerm   = 6;
   localparam int FbPrefix = 7;

   localparam logic [7:0] RexBase = 8'h40;
   localparam logic [7:0] RexW    = 8'h48;
   localparam logic [7:0] RexR    = 8'h04;
   localparam logic [7:0] RexB    = 8'h01;
   localparam logic [7:0] ModReg  = 8'hC0;
   localparam logic [7:0] ModD8   = 8'h40;
   localparam logic [7:0] ModD32  = 8'h80;
   localparam logic [7:0] RmSib   = 8'h04;

   typedef struct packed {
      logic [31:0] opcode_value;
      logic [2:0]  opcode_length;
      logic [2:0]  opcode_extension;
      logic [7:0]  prefix_byte;
      logic [31:0] immediate;
      logic [7:0]  form_bits;
      logic [1:0]  scale_code;
      logic        wide_operands;
      logic [3:0]  source_reg;
      logic [3:0]  index_reg;
      logic [3:0]  target_reg;
   } req_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last_byte;
   } rsp_type;

   // One classified instruction: all byte slots plus which of them are sent
   typedef struct packed {
      logic [NumSlots-1:0]      mask;
      logic [NumSlots-1:0][7:0] bytes;
   } desc_type;

   function automatic logic [7:0] build_modrm(input logic [7:0] fb,
                                              input logic [2:0] ext,
                                              input logic [3:0] src,
                                              input logic [3:0] tgt);
      logic [7:0] m;
      logic [2:0] other;
      m     = 8'h00;
      other = fb[FbSame] ? tgt[2:0] : src[2:0];
      if (fb[FbSingle]) m = m | {2'b00, ext, 3'b000};
      if (fb[FbSib])    m = m | RmSib;
      if (fb[FbMem]) begin
         if (fb[FbImm8])  m = m | ModD8;
         if (fb[FbImm32]) m = m | ModD32;
      end else begin
         m = m | ModReg;
      end
      if (!fb[FbMem] && !fb[FbSingle]) m = m | {2'b00, other, 3'b000};
      if (fb[FbMem] && !fb[FbSib])     m = m | {5'b00000, other};
      if (fb[FbMem]) m = m | {2'b00, tgt[2:0], 3'b000};
      else           m = m | {5'b00000, tgt[2:0]};
      if (fb[FbPerm]) begin
         if (fb[FbSingle]) m = {m[7:3], src[2:0]};
         else              m = {m[7:6], m[2:0], m[5:3]};
      end
      return m;
   endfunction

endpackage

// ===== sv/x86_instruction_encoder.sv =====
// x86-64 instruction encoder: one instruction description in, its bytes out.
// The request side pushes a description (req_push while req_full is low);
// the response side offers one machine-code byte at a time on rsp_data
// while rsp_empty is low, with last_byte set on the final byte, and the
// receiver takes it with rsp_pop.
// Byte order: repeat prefix, REX, one to four opcode bytes, ModRM, SIB,
// imm8, imm32 (little-endian), 2 to 13 bytes per instruction.
// The first byte passes a queue entry, the sequencer and the result register.
// Throughput: one byte per cycle through the single result register while the
// receiver keeps taking bytes; the sequencer loads the next instruction on the
// beat that sends its predecessor's last byte.
// A two-entry queue sits between the classifying front end and the byte
// sequencer, so requests keep being accepted while bytes drain.
// When the receiver stalls, the current byte holds, the sequencer waits and
// the queue fills; req_full rises once both entries are taken.
// Reset (synchronous) empties the queue, the sequencer and the result register.
// Depends on xie_pkg, xie_front, xie_queue and xie_back.
module x86_instruction_encoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  xie_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output xie_pkg::rsp_type rsp_data
);

   xie_pkg::desc_type front_desc;
   xie_pkg::desc_type q_data;
   logic              q_valid, q_pop;

   xie_front u_front (
      .req  (req_data),
      .desc (front_desc)
   );

   xie_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_push),
      .wr_data  (front_desc),
      .full     (req_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_data)
   );

   xie_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/xie_front.sv =====
// Front end: classifies one instruction description into byte slots.
// Depends on xie_pkg for the request and slot descriptor types.
module xie_front (
   input  xie_pkg::req_type  req,
   output xie_pkg::desc_type desc
);

   logic       need_rex;
   logic       swap;
   logic [7:0] rex;
   logic [7:0] fb;

   assign fb = req.form_bits;

   always_comb begin
      need_rex = req.wide_operands | req.target_reg[3] | req.source_reg[3] |
                 req.index_reg[3];
      swap = fb[xie_pkg::FbPerm] | fb[xie_pkg::FbMem];
      rex  = xie_pkg::RexBase;
      if (req.wide_operands) rex = rex | xie_pkg::RexW;
      if (req.target_reg[3]) rex = rex | (swap ? xie_pkg::RexR : xie_pkg::RexB);
      if (req.source_reg[3]) rex = rex | (swap ? xie_pkg::RexB : xie_pkg::RexR);

      desc = '0;
      desc.bytes[xie_pkg::SlotPrefix] = req.prefix_byte;
      desc.bytes[xie_pkg::SlotRex]    = rex;
      desc.bytes[xie_pkg::SlotOp3]    = req.opcode_value[31:24];
      desc.bytes[xie_pkg::SlotOp2]    = req.opcode_value[23:16];
      desc.bytes[xie_pkg::SlotOp1]    = req.opcode_value[15:8];
      desc.bytes[xie_pkg::SlotOp0]    = req.opcode_value[7:0];
      desc.bytes[xie_pkg::SlotModrm]  = xie_pkg::build_modrm(fb, req.opcode_extension,
                                                             req.source_reg,
                                                             req.target_reg);
      desc.bytes[xie_pkg::SlotSib]    = {req.scale_code, req.index_reg[2:0],
                                         req.source_reg[2:0]};
      desc.bytes[xie_pkg::SlotImm8]   = req.immediate[7:0];
      desc.bytes[xie_pkg::SlotImm32]     = req.immediate[7:0];
      desc.bytes[xie_pkg::SlotImm32 + 1] = req.immediate[15:8];
      desc.bytes[xie_pkg::SlotImm32 + 2] = req.immediate[23:16];
      desc.bytes[xie_pkg::SlotImm32 + 3] = req.immediate[31:24];

      desc.mask[xie_pkg::SlotPrefix] = fb[xie_pkg::FbPrefix];
      desc.mask[xie_pkg::SlotRex]    = need_rex;
      // lengths above four saturate, zero still sends the final byte
      desc.mask[xie_pkg::SlotOp3]    = req.opcode_length >= 3'd4;
      desc.mask[xie_pkg::SlotOp2]    = req.opcode_length >= 3'd3;
      desc.mask[xie_pkg::SlotOp1]    = req.opcode_length >= 3'd2;
      desc.mask[xie_pkg::SlotOp0]    = 1'b1;
      desc.mask[xie_pkg::SlotModrm]  = 1'b1;
      desc.mask[xie_pkg::SlotSib]    = fb[xie_pkg::FbSib];
      desc.mask[xie_pkg::SlotImm8]   = fb[xie_pkg::FbImm8];
      desc.mask[xie_pkg::SlotImm32]     = fb[xie_pkg::FbImm32];
      desc.mask[xie_pkg::SlotImm32 + 1] = fb[xie_pkg::FbImm32];
      desc.mask[xie_pkg::SlotImm32 + 2] = fb[xie_pkg::FbImm32];
      desc.mask[xie_pkg::SlotImm32 + 3] = fb[xie_pkg::FbImm32];
   end

endmodule

// ===== sv/xie_queue.sv =====
// Two-entry queue of classified instructions between front and back end.
// Depends on xie_pkg for the descriptor type.
module xie_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  xie_pkg::desc_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output logic              rd_valid,
   output xie_pkg::desc_type rd_data
);

   xie_pkg::desc_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign full     = count_ff == 2'd2;
   assign rd_valid = count_ff != 2'd0;
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_en & ~full;
   assign do_rd    = rd_en & rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) count_in = count_ff + 2'd1;
      if (do_rd && !do_wr) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) entry_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

// ===== sv/xie_back.sv =====
// Back end: walks the sent slots of one instruction into the result register,
// a byte a beat unless stalled; xie_pkg gives descriptor and result types.
module xie_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  xie_pkg::desc_type q_data,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output xie_pkg::rsp_type  rsp_data
);

   logic [xie_pkg::NumSlots-1:0]      mask_ff, mask_in;
   logic [xie_pkg::NumSlots-1:0][7:0] bytes_ff;
   logic                              out_valid_ff, out_valid_in;
   xie_pkg::rsp_type                  out_ff, out_in;
   logic [xie_pkg::SlotW-1:0]         sel;
   logic [xie_pkg::NumSlots-1:0]      mask_after;
   logic                              active, out_free, emit, load;

   assign active   = |mask_ff;
   assign out_free = ~out_valid_ff | rsp_pop;
   assign emit     = active & out_free;

   // lowest pending slot goes next
   always_comb begin
      sel = '0;
      for (int i = xie_pkg::NumSlots - 1; i >= 0; i--) begin
         if (mask_ff[i]) sel = xie_pkg::SlotW'(i);
      end
   end

   assign mask_after = mask_ff & ~({{(xie_pkg::NumSlots-1){1'b0}}, 1'b1} << sel);
   // take the next instruction on the beat that sends the last byte
   assign load  = q_valid & (~active | (emit & (mask_after == '0)));
   assign q_pop = load;

   always_comb begin
      mask_in = mask_ff;
      if (load)      mask_in = q_data.mask;
      else if (emit) mask_in = mask_after;
      out_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
      out_in       = out_ff;
      if (emit) begin
         out_in.code_byte = bytes_ff[sel];
         out_in.last_byte = mask_after == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (load) bytes_ff <= q_data.bytes;
   end

   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
